// ===== design/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int          QUEUE_DEPTH_DEF = 4;
    localparam logic [15:0] PHASE_TICKS_RST = 16'd100;

    // Input operation codes as they arrive on the channel.
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_STOP      = 3'd2;
    localparam logic [2:0] OP_WRITE     = 3'd3;
    localparam logic [2:0] OP_READ_ACK  = 3'd4;
    localparam logic [2:0] OP_READ_NACK = 3'd5;

    // Completion status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_ERR   = 2'd2;
    localparam logic [1:0] ST_NOACK = 2'd3;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ_ACK,
        CMD_READ_NACK
    } t_cmd;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_ST_A   = 5'd1,
        PH_ST_B   = 5'd2,
        PH_ST_C   = 5'd3,
        PH_ST_D   = 5'd4,
        PH_SP_A   = 5'd5,
        PH_SP_B   = 5'd6,
        PH_W_LOW  = 5'd7,
        PH_W_SET  = 5'd8,
        PH_W_HIGH = 5'd9,
        PH_A_LOW  = 5'd10,
        PH_A_HIGH = 5'd11,
        PH_R_LOW  = 5'd12,
        PH_R_HIGH = 5'd13,
        PH_K_LOW  = 5'd14,
        PH_K_HIGH = 5'd15
    } t_phase;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data_byte;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] read_byte;
    } t_out_item;

    // Classified item held in the queue between front and back.
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data_byte;
        logic       sda_in;
    } t_q_item;

endpackage

// ===== design/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts input transfers, decodes the operation and queues the result.
// ----------------------------------------------------------------------------
module i2cm_front
    import i2cm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    output logic     o_q_valid,
    input  logic     i_q_pop,
    output t_q_item  o_q_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Operation codes six and seven behave as ticks.
    function automatic t_cmd classify(input logic [2:0] op);
        t_cmd c;
        case (op)
            OP_START:     c = CMD_START;
            OP_STOP:      c = CMD_STOP;
            OP_WRITE:     c = CMD_WRITE;
            OP_READ_ACK:  c = CMD_READ_ACK;
            OP_READ_NACK: c = CMD_READ_NACK;
            default:      c = CMD_TICK;
        endcase
        return c;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    t_q_item          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push;
    logic             w_pop;
    t_q_item          w_new;

    assign o_stall   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_count != '0);
    assign w_pop     = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rd_ptr];

    always_comb begin
        w_new.cmd       = classify(i_item.op);
        w_new.data_byte = i_item.data_byte;
        w_new.sda_in    = i_item.sda_in;
    end

    always_comb begin
        n_wr_ptr = w_push ? ptr_next(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = w_pop ? ptr_next(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_new;
        end
    end

endmodule

// ===== design/i2cm_back.sv =====
// ----------------------------------------------------------------------------
// i2cm_back
// Bus engine: steps the phase sequencer once per queued item and registers
// one result for each.
// ----------------------------------------------------------------------------
module i2cm_back
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_phase_ticks,
    input  t_q_item     i_q_item,
    input  logic        i_q_valid,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_out_item
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_bit_count, n_bit_count;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_wait, n_wait;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic [1:0]  r_status, n_status;
    logic        r_nack, n_nack;
    logic [7:0]  r_rx, n_rx;
    logic        n_done;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        w_step;
    logic        w_idle;
    logic        w_tick;
    logic [15:0] w_wait_inc;
    logic [15:0] w_limit;
    logic        w_end;
    logic [3:0]  w_bit_inc;
    logic        w_more_bits;

    // An item is taken when the result register is free or being emptied.
    assign w_step  = i_q_valid && (!r_out_valid || !i_stall);
    assign o_q_pop = w_step;

    assign w_idle      = (r_phase == PH_IDLE);
    assign w_tick      = (i_q_item.cmd == CMD_TICK);
    assign w_wait_inc  = r_wait + 16'd1;
    assign w_limit     = (i_phase_ticks == '0) ? 16'd1 : i_phase_ticks;
    assign w_end       = !w_idle && w_tick &&
                         ((w_wait_inc >= w_limit) || (w_wait_inc == '0));
    assign w_bit_inc   = r_bit_count + 4'd1;
    assign w_more_bits = !w_bit_inc[3];

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (w_idle) begin
            case (i_q_item.cmd)
                CMD_START:     n_phase = PH_ST_A;
                CMD_STOP:      n_phase = PH_SP_A;
                CMD_WRITE:     n_phase = PH_W_LOW;
                CMD_READ_ACK:  n_phase = PH_R_LOW;
                CMD_READ_NACK: n_phase = PH_R_LOW;
                default:       n_phase = PH_IDLE;
            endcase
        end else if (w_end) begin
            case (r_phase)
                PH_ST_A:   n_phase = PH_ST_B;
                PH_ST_B:   n_phase = i_q_item.sda_in ? PH_ST_C : PH_IDLE;
                PH_ST_C:   n_phase = PH_ST_D;
                PH_SP_A:   n_phase = PH_SP_B;
                PH_W_LOW:  n_phase = PH_W_SET;
                PH_W_SET:  n_phase = PH_W_HIGH;
                PH_W_HIGH: n_phase = w_more_bits ? PH_W_LOW : PH_A_LOW;
                PH_A_LOW:  n_phase = PH_A_HIGH;
                PH_R_LOW:  n_phase = PH_R_HIGH;
                PH_R_HIGH: n_phase = w_more_bits ? PH_R_LOW : PH_K_LOW;
                PH_K_LOW:  n_phase = PH_K_HIGH;
                default:   n_phase = PH_IDLE;
            endcase
        end
    end

    // Drive levels, shifter, timer and status.
    always_comb begin
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_wait      = r_wait;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_status    = r_status;
        n_nack      = r_nack;
        n_rx        = r_rx;
        n_done      = 1'b0;
        if (w_idle) begin
            case (i_q_item.cmd)
                CMD_START: begin
                    n_sda  = 1'b1;
                    n_wait = '0;
                end
                CMD_STOP: begin
                    n_sda  = 1'b0;
                    n_wait = '0;
                end
                CMD_WRITE: begin
                    n_shift     = i_q_item.data_byte;
                    n_bit_count = '0;
                    n_scl       = 1'b0;
                    n_wait      = '0;
                end
                CMD_READ_ACK, CMD_READ_NACK: begin
                    n_shift     = '0;
                    n_bit_count = '0;
                    n_scl       = 1'b0;
                    n_sda       = 1'b1;
                    n_nack      = (i_q_item.cmd == CMD_READ_NACK);
                    n_wait      = '0;
                end
                default: begin
                end
            endcase
        end else if (w_tick && !w_end) begin
            n_wait = w_wait_inc;
        end else if (w_end) begin
            n_wait = '0;
            case (r_phase)
                PH_ST_A: n_scl = 1'b1;
                PH_ST_B: begin
                    if (!i_q_item.sda_in) begin
                        n_status = ST_BUSY;
                        n_done   = 1'b1;
                    end else begin
                        n_sda = 1'b0;
                    end
                end
                PH_ST_C: n_scl = 1'b0;
                PH_ST_D: begin
                    n_status = i_q_item.sda_in ? ST_ERR : ST_OK;
                    n_done   = 1'b1;
                end
                PH_SP_A: n_scl = 1'b1;
                PH_SP_B: begin
                    n_sda    = 1'b1;
                    n_status = ST_OK;
                    n_done   = 1'b1;
                end
                PH_W_LOW: begin
                    n_sda   = r_shift[7];
                    n_shift = {r_shift[6:0], 1'b0};
                end
                PH_W_SET: n_scl = 1'b1;
                PH_W_HIGH: begin
                    n_bit_count = w_bit_inc;
                    n_scl       = 1'b0;
                    if (!w_more_bits) begin
                        n_sda = 1'b1;
                    end
                end
                PH_A_LOW: n_scl = 1'b1;
                PH_A_HIGH: begin
                    n_scl    = 1'b0;
                    n_status = i_q_item.sda_in ? ST_NOACK : ST_OK;
                    n_done   = 1'b1;
                end
                PH_R_LOW: n_scl = 1'b1;
                PH_R_HIGH: begin
                    n_shift     = {r_shift[6:0], i_q_item.sda_in};
                    n_bit_count = w_bit_inc;
                    n_scl       = 1'b0;
                    if (!w_more_bits) begin
                        n_sda = r_nack;
                    end
                end
                PH_K_LOW: n_scl = 1'b1;
                PH_K_HIGH: begin
                    n_scl    = 1'b0;
                    n_rx     = r_shift;
                    n_status = ST_OK;
                    n_done   = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_count <= '0;
            r_shift     <= '0;
            r_wait      <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_status    <= ST_OK;
            r_nack      <= 1'b0;
            r_rx        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_phase     <= n_phase;
                r_bit_count <= n_bit_count;
                r_shift     <= n_shift;
                r_wait      <= n_wait;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_status    <= n_status;
                r_nack      <= n_nack;
                r_rx        <= n_rx;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out.scl_level <= n_scl;
            r_out.sda_level <= n_sda;
            r_out.busy_res  <= (n_phase != PH_IDLE);
            r_out.done_res  <= n_done;
            r_out.status    <= n_status;
            r_out.read_byte <= n_rx;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_item = r_out;

endmodule

// ===== design/i2c_master_byte_engine.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master that carries out one bus command at a time, timed by ticks.
// ----------------------------------------------------------------------------
// Usage: each input transfer carries an operation (tick, start, stop, write
// byte, read with ACK, read with NACK), a data byte and the sampled SDA level.
// A command is taken only while the engine is idle; ticks then step it
// through timed phases of phase_ticks ticks each. Every input transfer gives
// exactly one result transfer with the driven SCL and SDA levels, busy, a
// done pulse, the last status and the last received byte.
// An accepted input is registered in the queue, then in the result register;
// throughput is one item per cycle while the receiver does not stall. A short
// queue sits between the decoder and the bus engine, and the engine's result
// register lets a new item be taken while a result waits, as long as the
// receiver takes it. When the receiver stalls, the engine holds its result
// and the queue fills; o_stall rises only when the queue is full. Reset clears
// the queue and the engine: both lines released, idle, status ok, received
// byte zero, phase_ticks back to 100. The user must write the phase_ticks
// register via i_cfg_wr_en and i_cfg_wr_data only while idle (unenforced).
// ----------------------------------------------------------------------------
module i2c_master_byte_engine
    import i2cm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_in_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_out_item
);

    // Ticks per half-bit phase; zero is treated as one by the engine.
    logic [15:0] r_phase_ticks;

    t_q_item w_q_item;
    logic    w_q_valid;
    logic    w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
        end else if (i_cfg_wr_en) begin
            r_phase_ticks <= i_cfg_wr_data;
        end
    end

    // The front decodes each transfer and queues it for the engine.
    i2cm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (i_in_item),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop),
        .o_q_item  (w_q_item)
    );

    // The engine takes the queue head whenever its result register is free.
    i2cm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_phase_ticks (r_phase_ticks),
        .i_q_item      (w_q_item),
        .i_q_valid     (w_q_valid),
        .o_q_pop       (w_q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_item    (o_out_item)
    );

endmodule
